// File: hdl/jdc_pkg.sv
// ----------------------------------------------------------------------------
// jdc_pkg
// Shared codes, control state type and byte classes for the descriptor checker.
// ----------------------------------------------------------------------------
package jdc_pkg;

    // check modes
    localparam logic [1:0] MODE_METHOD = 2'd0;
    localparam logic [1:0] MODE_FIELD  = 2'd1;
    localparam logic [1:0] MODE_IDENT  = 2'd2;
    localparam logic [1:0] MODE_CLASS  = 2'd3;

    // verdict codes
    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_MALF  = 2'd1;
    localparam logic [1:0] STATUS_DIMS  = 2'd2;

    // parse phases
    localparam logic [2:0] PH_START   = 3'd0;
    localparam logic [2:0] PH_ARGS    = 3'd1;
    localparam logic [2:0] PH_RET     = 3'd2;
    localparam logic [2:0] PH_ARR_ARG = 3'd3;
    localparam logic [2:0] PH_ARR_END = 3'd4;
    localparam logic [2:0] PH_CLS_ARG = 3'd5;
    localparam logic [2:0] PH_CLS_END = 3'd6;
    localparam logic [2:0] PH_DONE    = 3'd7;

    // descriptor characters
    localparam logic [7:0] CH_LBRACK = 8'h5B; // '['
    localparam logic [7:0] CH_CLASS  = 8'h4C; // 'L'
    localparam logic [7:0] CH_SEMI   = 8'h3B; // ';'
    localparam logic [7:0] CH_VOID   = 8'h56; // 'V'
    localparam logic [7:0] CH_LPAREN = 8'h28; // '('
    localparam logic [7:0] CH_RPAREN = 8'h29; // ')'
    localparam logic [7:0] CH_SLASH  = 8'h2F; // '/'
    localparam logic [7:0] CH_DOT    = 8'h2E; // '.'

    // per-string control state
    typedef struct packed {
        logic [2:0] phase;
        logic       prev_slash;
        logic       name_nonempty;
        logic [1:0] err;
    } t_ctl_state;

    localparam t_ctl_state CTL_RESET = '{
        phase:         PH_START,
        prev_slash:    1'b0,
        name_nonempty: 1'b0,
        err:           STATUS_OK
    };

    // slot count of a base type, zero for anything else
    function automatic logic [1:0] base_slots(input logic [7:0] b);
        logic [1:0] s;
        case (b) inside
            8'h42, 8'h43, 8'h46, 8'h49, 8'h53, 8'h5A: s = 2'd1; // B C F I S Z
            8'h44, 8'h4A:                             s = 2'd2; // D J
            default:                                  s = 2'd0;
        endcase
        return s;
    endfunction

endpackage

// File: hdl/jdc_step.sv
// ----------------------------------------------------------------------------
// jdc_step
// Next-state and verdict logic for one byte of a descriptor or identifier.
// ----------------------------------------------------------------------------
module jdc_step #(
    parameter int MAX_DIMENSIONS = 255,
    parameter int SLOT_WIDTH     = 16,
    parameter int DIM_W          = 9
) (
    input  logic [7:0]             i_byte,
    input  logic                   i_last,
    input  logic [1:0]             i_mode,
    input  jdc_pkg::t_ctl_state    i_ctl,
    input  logic [DIM_W-1:0]       i_dim,
    input  logic [SLOT_WIDTH-1:0]  i_slot,
    output jdc_pkg::t_ctl_state    o_ctl,
    output logic [DIM_W-1:0]       o_dim,
    output logic [SLOT_WIDTH-1:0]  o_slot,
    output logic [1:0]             o_status,
    output logic [15:0]            o_slot_total
);

    localparam logic [DIM_W-1:0]      DIM_MAX  = DIM_W'(MAX_DIMENSIONS);
    localparam logic [SLOT_WIDTH:0]   SLOT_LIM = {1'b0, {SLOT_WIDTH{1'b1}}};

    jdc_pkg::t_ctl_state      n_ctl;
    logic [DIM_W-1:0]         n_dim;
    logic [SLOT_WIDTH-1:0]    n_slot;
    logic                     in_arg;
    logic                     do_begin;
    logic                     do_enter;
    logic                     do_fin;
    logic [1:0]               fin_slots;
    logic [1:0]               fail_code;
    logic [1:0]               b_slots;
    logic [SLOT_WIDTH:0]      sum;
    logic [1:0]               status;
    logic [SLOT_WIDTH+15:0]   slot_ext;

    assign b_slots = jdc_pkg::base_slots(i_byte);

    // byte decode and state update
    always_comb begin
        n_ctl     = i_ctl;
        n_dim     = i_dim;
        n_slot    = i_slot;
        in_arg    = 1'b0;
        do_begin  = 1'b0;
        do_enter  = 1'b0;
        do_fin    = 1'b0;
        fin_slots = 2'd1;
        fail_code = jdc_pkg::STATUS_OK;
        sum       = '0;

        if (i_ctl.err == jdc_pkg::STATUS_OK) begin
            if (i_mode == jdc_pkg::MODE_IDENT || i_mode == jdc_pkg::MODE_CLASS) begin
                // plain text check
                if (i_byte == jdc_pkg::CH_SEMI || i_byte == jdc_pkg::CH_DOT ||
                    i_byte == jdc_pkg::CH_LBRACK) begin
                    fail_code = jdc_pkg::STATUS_MALF;
                end else if (i_byte == jdc_pkg::CH_SLASH) begin
                    if (i_mode != jdc_pkg::MODE_CLASS || i_ctl.prev_slash) begin
                        fail_code = jdc_pkg::STATUS_MALF;
                    end
                    n_ctl.prev_slash = 1'b1;
                end else begin
                    n_ctl.prev_slash = 1'b0;
                end
            end else begin
                unique case (i_ctl.phase) inside
                    jdc_pkg::PH_START: begin
                        if (i_mode == jdc_pkg::MODE_METHOD) begin
                            if (i_byte == jdc_pkg::CH_LPAREN) begin
                                n_ctl.phase = jdc_pkg::PH_ARGS;
                            end else begin
                                fail_code = jdc_pkg::STATUS_MALF;
                            end
                        end else begin
                            do_begin = 1'b1;
                        end
                    end
                    jdc_pkg::PH_ARGS: begin
                        in_arg = 1'b1;
                        if (i_byte == jdc_pkg::CH_RPAREN) begin
                            n_ctl.phase = jdc_pkg::PH_RET;
                        end else begin
                            do_begin = 1'b1;
                        end
                    end
                    jdc_pkg::PH_RET: begin
                        if (i_byte == jdc_pkg::CH_VOID) begin
                            n_ctl.phase = jdc_pkg::PH_DONE;
                        end else begin
                            do_begin = 1'b1;
                        end
                    end
                    jdc_pkg::PH_ARR_ARG, jdc_pkg::PH_ARR_END: begin
                        in_arg = (i_ctl.phase == jdc_pkg::PH_ARR_ARG);
                        if (i_byte == jdc_pkg::CH_LBRACK) begin
                            if (i_dim <= DIM_MAX) begin
                                n_dim = i_dim + DIM_W'(1);
                            end
                        end else if (i_dim > DIM_MAX) begin
                            fail_code = (i_mode == jdc_pkg::MODE_FIELD) ?
                                        jdc_pkg::STATUS_DIMS : jdc_pkg::STATUS_MALF;
                        end else if (i_byte == jdc_pkg::CH_CLASS) begin
                            do_enter = 1'b1;
                        end else if (b_slots != 2'd0) begin
                            do_fin = 1'b1;
                        end else begin
                            fail_code = jdc_pkg::STATUS_MALF;
                        end
                    end
                    jdc_pkg::PH_CLS_ARG, jdc_pkg::PH_CLS_END: begin
                        in_arg = (i_ctl.phase == jdc_pkg::PH_CLS_ARG);
                        if (i_byte == jdc_pkg::CH_SEMI) begin
                            if (!i_ctl.name_nonempty || i_ctl.prev_slash) begin
                                fail_code = jdc_pkg::STATUS_MALF;
                            end else begin
                                do_fin = 1'b1;
                            end
                        end else if (i_byte == jdc_pkg::CH_DOT ||
                                     i_byte == jdc_pkg::CH_LBRACK) begin
                            fail_code = jdc_pkg::STATUS_MALF;
                        end else if (i_byte == jdc_pkg::CH_SLASH) begin
                            if (i_ctl.prev_slash) begin
                                fail_code = jdc_pkg::STATUS_MALF;
                            end
                            n_ctl.prev_slash    = 1'b1;
                            n_ctl.name_nonempty = 1'b1;
                        end else begin
                            n_ctl.prev_slash    = 1'b0;
                            n_ctl.name_nonempty = 1'b1;
                        end
                    end
                    default: begin
                        // trailing byte after a complete descriptor
                        fail_code = jdc_pkg::STATUS_MALF;
                    end
                endcase

                // start of a new field type
                if (do_begin) begin
                    if (i_byte == jdc_pkg::CH_LBRACK) begin
                        n_dim       = DIM_W'(1);
                        n_ctl.phase = in_arg ? jdc_pkg::PH_ARR_ARG : jdc_pkg::PH_ARR_END;
                    end else if (i_byte == jdc_pkg::CH_CLASS) begin
                        do_enter = 1'b1;
                    end else if (b_slots != 2'd0) begin
                        do_fin    = 1'b1;
                        fin_slots = b_slots;
                    end else begin
                        fail_code = jdc_pkg::STATUS_MALF;
                    end
                end

                // open a class name
                if (do_enter) begin
                    n_ctl.name_nonempty = 1'b0;
                    n_ctl.prev_slash    = 1'b0;
                    n_ctl.phase = in_arg ? jdc_pkg::PH_CLS_ARG : jdc_pkg::PH_CLS_END;
                end

                // type complete: count slots for arguments
                if (do_fin) begin
                    if (in_arg) begin
                        sum         = {1'b0, i_slot} + (SLOT_WIDTH+1)'(fin_slots);
                        n_slot      = (sum > SLOT_LIM) ? {SLOT_WIDTH{1'b1}} :
                                                         sum[SLOT_WIDTH-1:0];
                        n_ctl.phase = jdc_pkg::PH_ARGS;
                    end else begin
                        n_ctl.phase = jdc_pkg::PH_DONE;
                    end
                end
            end

            if (fail_code != jdc_pkg::STATUS_OK) begin
                n_ctl.err = fail_code;
            end
        end
    end

    // verdict from the updated state
    always_comb begin
        if (n_ctl.err != jdc_pkg::STATUS_OK) begin
            status = n_ctl.err;
        end else if (i_mode == jdc_pkg::MODE_IDENT || i_mode == jdc_pkg::MODE_CLASS) begin
            status = n_ctl.prev_slash ? jdc_pkg::STATUS_MALF : jdc_pkg::STATUS_OK;
        end else begin
            status = (n_ctl.phase == jdc_pkg::PH_DONE) ? jdc_pkg::STATUS_OK :
                                                         jdc_pkg::STATUS_MALF;
        end
    end

    assign slot_ext = {16'd0, n_slot};
    assign o_status = status;

    always_comb begin
        if (status == jdc_pkg::STATUS_OK && i_mode == jdc_pkg::MODE_METHOD) begin
            o_slot_total = (slot_ext > (SLOT_WIDTH+16)'(16'hFFFF)) ? 16'hFFFF :
                                                                     slot_ext[15:0];
        end else begin
            o_slot_total = 16'd0;
        end
    end

    // string state returns to reset after the final byte
    assign o_ctl  = i_last ? jdc_pkg::CTL_RESET : n_ctl;
    assign o_dim  = i_last ? '0 : n_dim;
    assign o_slot = i_last ? '0 : n_slot;

endmodule

// File: hdl/jvm_descriptor_checker_unit.sv
// Path: a final byte's verdict passes through the input register, then the result register.
// Throughput: one byte per cycle; the input register drains into the parse
// state every cycle, and stalls only when a final byte meets a full result
// register that is not being taken.
// Reset: synchronous, active low; clears the mode register to method mode, the parse state and
// both valid flags.
// ----------------------------------------------------------------------------
// jvm_descriptor_checker_unit
// Byte-serial checker for JVM method, field, identifier and class-name text.
// ----------------------------------------------------------------------------
module jvm_descriptor_checker_unit #(
    parameter int MAX_DIMENSIONS = 255,
    parameter int SLOT_WIDTH     = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_wdata,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_sig_byte,
    input  logic        i_last_byte,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_status,
    output logic [15:0] o_slot_total
);

    localparam int DIM_W = $clog2(MAX_DIMENSIONS + 2);

    logic [1:0]              r_mode;
    logic                    r_in_valid;
    logic [7:0]              r_in_byte;
    logic                    r_in_last;
    jdc_pkg::t_ctl_state     r_ctl;
    logic [DIM_W-1:0]        r_dim;
    logic [SLOT_WIDTH-1:0]   r_slot;
    logic                    r_out_valid;
    logic [1:0]              r_out_status;
    logic [15:0]             r_out_slots;

    jdc_pkg::t_ctl_state     n_ctl;
    logic [DIM_W-1:0]        n_dim;
    logic [SLOT_WIDTH-1:0]   n_slot;
    logic [1:0]              n_status;
    logic [15:0]             n_slots;
    logic                    in_adv;
    logic                    out_free;

    // handshake: the held byte moves on unless it needs a busy result slot
    assign out_free = !r_out_valid || i_ready;
    assign in_adv   = r_in_valid && (!r_in_last || out_free);
    assign o_ready  = !r_in_valid || in_adv;

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= jdc_pkg::MODE_METHOD;
        end else if (i_cfg_we) begin
            r_mode <= i_cfg_wdata;
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in_byte <= i_sig_byte;
            r_in_last <= i_last_byte;
        end
    end

    jdc_step #(
        .MAX_DIMENSIONS (MAX_DIMENSIONS),
        .SLOT_WIDTH     (SLOT_WIDTH),
        .DIM_W          (DIM_W)
    ) u_step (
        .i_byte       (r_in_byte),
        .i_last       (r_in_last),
        .i_mode       (r_mode),
        .i_ctl        (r_ctl),
        .i_dim        (r_dim),
        .i_slot       (r_slot),
        .o_ctl        (n_ctl),
        .o_dim        (n_dim),
        .o_slot       (n_slot),
        .o_status     (n_status),
        .o_slot_total (n_slots)
    );

    // parse state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl  <= jdc_pkg::CTL_RESET;
            r_dim  <= '0;
            r_slot <= '0;
        end else if (in_adv) begin
            r_ctl  <= n_ctl;
            r_dim  <= n_dim;
            r_slot <= n_slot;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_adv && r_in_last) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_adv && r_in_last) begin
            r_out_status <= n_status;
            r_out_slots  <= n_slots;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_status     = r_out_status;
    assign o_slot_total = r_out_slots;

    // a delivered verdict is one of the defined codes
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_status == jdc_pkg::STATUS_OK || o_status == jdc_pkg::STATUS_MALF ||
                     o_status == jdc_pkg::STATUS_DIMS))
        else $error("undefined status code delivered");

    // slot count only accompanies a valid verdict
    a_slots_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != jdc_pkg::STATUS_OK) |-> (o_slot_total == 16'd0))
        else $error("slot count on a failed verdict");

    // a final byte clears the parse state
    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_adv && r_in_last) |=>
            (r_ctl == jdc_pkg::CTL_RESET && r_dim == '0 && r_slot == '0))
        else $error("parse state not cleared after final byte");

    // dimension counter stays within its limit plus one
    a_dim_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_dim <= DIM_W'(MAX_DIMENSIONS + 1))
        else $error("dimension counter overflow");

    // a final byte waits while the result register is stalled
    a_hold_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && r_in_last && r_out_valid && !i_ready) |=> r_in_valid)
        else $error("final byte dropped while result stalled");

endmodule

// File: sim/jdc_verdict_monitor.sv
// ----------------------------------------------------------------------------
// jdc_verdict_monitor
// Watches the byte and verdict channels of the descriptor checker, tracks the
// parse of each string on its own and compares every verdict in order.
// ----------------------------------------------------------------------------
module jdc_verdict_monitor (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_wdata,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [7:0]  i_sig_byte,
    input  logic        i_last_byte,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [1:0]  i_status,
    input  logic [15:0] i_slot_total,
    output int          o_pending,
    output int          o_mismatches
);

    localparam int unsigned MAX_DIMS = 255;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] slots;
    } t_verdict;

    // verdicts owed by the block, oldest first
    t_verdict verdict_q[$];

    // shadow of the mode register and of the per-string parse
    logic [1:0]  mode_q;
    logic [2:0]  ph;
    int unsigned dims;
    logic [15:0] slots;
    logic        slash_seen;
    logic        name_seen;
    logic [1:0]  err;

    int mismatch_count = 0;
    assign o_mismatches = mismatch_count;

    task automatic flag_mismatch(input string what);
        $display("verdict mismatch: %s", what);
        mismatch_count++;
    endtask

    function automatic int unsigned type_slots(input logic [7:0] b);
        case (b) inside
            "B", "C", "F", "I", "S", "Z": return 1;
            "D", "J":                     return 2;
            default:                      return 0;
        endcase
    endfunction

    task automatic clear_string();
        ph         = jdc_pkg::PH_START;
        dims       = 0;
        slots      = '0;
        slash_seen = 1'b0;
        name_seen  = 1'b0;
        err        = jdc_pkg::STATUS_OK;
    endtask

    // first error wins
    task automatic latch_err(input logic [1:0] code);
        if (err == jdc_pkg::STATUS_OK) err = code;
    endtask

    // a complete type: add its slots inside the argument list
    task automatic end_type(input bit in_arg, input int unsigned n);
        if (in_arg) begin
            if (32'(slots) + n > 32'hFFFF) slots = 16'hFFFF;
            else slots = slots + 16'(n);
            ph = jdc_pkg::PH_ARGS;
        end else begin
            ph = jdc_pkg::PH_DONE;
        end
    endtask

    task automatic open_class(input bit in_arg);
        name_seen  = 1'b0;
        slash_seen = 1'b0;
        ph         = in_arg ? jdc_pkg::PH_CLS_ARG : jdc_pkg::PH_CLS_END;
    endtask

    task automatic start_type(input logic [7:0] b, input bit in_arg);
        if (b == jdc_pkg::CH_LBRACK) begin
            dims = 1;
            ph   = in_arg ? jdc_pkg::PH_ARR_ARG : jdc_pkg::PH_ARR_END;
        end else if (b == jdc_pkg::CH_CLASS) begin
            open_class(in_arg);
        end else if (type_slots(b) != 0) begin
            end_type(in_arg, type_slots(b));
        end else begin
            latch_err(jdc_pkg::STATUS_MALF);
        end
    endtask

    // inside a run of '[': an array always takes one slot
    task automatic array_step(input logic [7:0] b, input bit in_arg);
        if (b == jdc_pkg::CH_LBRACK) begin
            if (dims <= MAX_DIMS) dims++;
        end else if (dims > MAX_DIMS) begin
            latch_err(mode_q == jdc_pkg::MODE_FIELD ? jdc_pkg::STATUS_DIMS :
                                                      jdc_pkg::STATUS_MALF);
        end else if (b == jdc_pkg::CH_CLASS) begin
            open_class(in_arg);
        end else if (type_slots(b) != 0) begin
            end_type(in_arg, 1);
        end else begin
            latch_err(jdc_pkg::STATUS_MALF);
        end
    endtask

    // class name between L and ';'
    task automatic class_step(input logic [7:0] b, input bit in_arg);
        if (b == jdc_pkg::CH_SEMI) begin
            if (!name_seen || slash_seen) latch_err(jdc_pkg::STATUS_MALF);
            else end_type(in_arg, 1);
        end else if (b == jdc_pkg::CH_DOT || b == jdc_pkg::CH_LBRACK) begin
            latch_err(jdc_pkg::STATUS_MALF);
        end else if (b == jdc_pkg::CH_SLASH) begin
            if (slash_seen) latch_err(jdc_pkg::STATUS_MALF);
            slash_seen = 1'b1;
            name_seen  = 1'b1;
        end else begin
            slash_seen = 1'b0;
            name_seen  = 1'b1;
        end
    endtask

    task automatic parse_byte(input logic [7:0] b);
        if (err != jdc_pkg::STATUS_OK) return;
        if (mode_q == jdc_pkg::MODE_IDENT || mode_q == jdc_pkg::MODE_CLASS) begin
            if (b == jdc_pkg::CH_SEMI || b == jdc_pkg::CH_DOT || b == jdc_pkg::CH_LBRACK) begin
                latch_err(jdc_pkg::STATUS_MALF);
            end else if (b == jdc_pkg::CH_SLASH) begin
                if (mode_q != jdc_pkg::MODE_CLASS || slash_seen)
                    latch_err(jdc_pkg::STATUS_MALF);
                slash_seen = 1'b1;
            end else begin
                slash_seen = 1'b0;
            end
        end else begin
            case (ph)
                jdc_pkg::PH_START: begin
                    if (mode_q == jdc_pkg::MODE_METHOD) begin
                        if (b == jdc_pkg::CH_LPAREN) ph = jdc_pkg::PH_ARGS;
                        else latch_err(jdc_pkg::STATUS_MALF);
                    end else begin
                        start_type(b, 1'b0);
                    end
                end
                jdc_pkg::PH_ARGS: begin
                    if (b == jdc_pkg::CH_RPAREN) ph = jdc_pkg::PH_RET;
                    else start_type(b, 1'b1);
                end
                jdc_pkg::PH_RET: begin
                    if (b == jdc_pkg::CH_VOID) ph = jdc_pkg::PH_DONE;
                    else start_type(b, 1'b0);
                end
                jdc_pkg::PH_ARR_ARG: array_step(b, 1'b1);
                jdc_pkg::PH_ARR_END: array_step(b, 1'b0);
                jdc_pkg::PH_CLS_ARG: class_step(b, 1'b1);
                jdc_pkg::PH_CLS_END: class_step(b, 1'b0);
                default:             latch_err(jdc_pkg::STATUS_MALF);
            endcase
        end
    endtask

    // verdict of the string that the final byte closes
    function automatic t_verdict string_verdict();
        t_verdict v;
        if (err != jdc_pkg::STATUS_OK)
            v.status = err;
        else if (mode_q == jdc_pkg::MODE_IDENT || mode_q == jdc_pkg::MODE_CLASS)
            v.status = slash_seen ? jdc_pkg::STATUS_MALF : jdc_pkg::STATUS_OK;
        else
            v.status = (ph == jdc_pkg::PH_DONE) ? jdc_pkg::STATUS_OK : jdc_pkg::STATUS_MALF;
        v.slots = (v.status == jdc_pkg::STATUS_OK && mode_q == jdc_pkg::MODE_METHOD) ?
                  slots : 16'd0;
        return v;
    endfunction

    // sample both channels and the mode write at the rising edge
    always @(posedge i_clk) begin
        t_verdict want;
        if (!i_rst_n) begin
            mode_q = jdc_pkg::MODE_METHOD;
            clear_string();
            verdict_q.delete();
        end else begin
            if (i_cfg_we) mode_q = i_cfg_wdata;
            if (i_in_valid && i_in_ready) begin
                parse_byte(i_sig_byte);
                if (i_last_byte) begin
                    verdict_q.push_back(string_verdict());
                    clear_string();
                end
            end
            if (i_out_valid && i_out_ready) begin
                if (verdict_q.size() == 0) begin
                    flag_mismatch($sformatf("unexpected verdict status=%0d slots=%0d",
                                            i_status, i_slot_total));
                end else begin
                    want = verdict_q.pop_front();
                    if (i_status !== want.status)
                        flag_mismatch($sformatf("status got %0d want %0d",
                                                i_status, want.status));
                    if (i_slot_total !== want.slots)
                        flag_mismatch($sformatf("slot_total got %0d want %0d",
                                                i_slot_total, want.slots));
                end
            end
        end
        o_pending <= verdict_q.size();
    end

endmodule

// File: sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Drives descriptor and identifier strings into the checker unit in all four
// modes, directed corner strings first and then random well-formed, broken
// and noise strings, with random idling on both channels.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_BYTES = 150;
    localparam int QUIET_TAIL   = 110;
    localparam logic [63:0] BASE_SET   = "BCDFIJSZ";
    localparam logic [55:0] TRICKY_SET = "/.;[L()";

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_cfg_we    = 1'b0;
    logic [1:0]  i_cfg_wdata = 2'd0;
    logic        i_valid     = 1'b0;
    logic [7:0]  i_sig_byte  = 8'd0;
    logic        i_last_byte = 1'b0;
    logic        i_ready     = 1'b0;
    logic        o_ready;
    logic        o_valid;
    logic [1:0]  o_status;
    logic [15:0] o_slot_total;

    int pending;
    int mismatches;
    int cycle_count = 0;
    int sent_bytes  = 0;
    bit src_idle    = 1'b0;
    bit sink_idle   = 1'b0;
    logic [7:0] text_q[$];

    always #2 i_clk = ~i_clk;

    jvm_descriptor_checker_unit i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_sig_byte   (i_sig_byte),
        .i_last_byte  (i_last_byte),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_status     (o_status),
        .o_slot_total (o_slot_total)
    );

    jdc_verdict_monitor i_monitor (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_in_valid   (i_valid),
        .i_in_ready   (o_ready),
        .i_sig_byte   (i_sig_byte),
        .i_last_byte  (i_last_byte),
        .i_out_valid  (o_valid),
        .i_out_ready  (i_ready),
        .i_status     (o_status),
        .i_slot_total (o_slot_total),
        .o_pending    (pending),
        .o_mismatches (mismatches)
    );

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb_top: done, errors");
            $finish;
        end
    end

    // verdict side stalls in bursts
    always begin
        @(negedge i_clk);
        if (sink_idle && $urandom_range(0, 3) == 0) begin
            i_ready <= 1'b0;
            repeat ($urandom_range(1, 14)) @(negedge i_clk);
        end
        i_ready <= 1'b1;
    end

    // one byte transfer, with an optional idle burst ahead of it
    task automatic send_byte(input logic [7:0] b, input logic last);
        @(negedge i_clk);
        if (src_idle && $urandom_range(0, 3) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(negedge i_clk);
        end
        i_valid     <= 1'b1;
        i_sig_byte  <= b;
        i_last_byte <= last;
        do @(posedge i_clk); while (!o_ready);
    endtask

    task automatic send_text();
        for (int k = 0; k < text_q.size(); k++)
            send_byte(text_q[k], k == text_q.size() - 1);
        sent_bytes += text_q.size();
    endtask

    // mode write once the block has drained
    task automatic set_mode(input logic [1:0] m);
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= m;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic add_str(input string s);
        for (int k = 0; k < s.len(); k++) text_q.push_back(s[k]);
    endtask

    task automatic add_run(input logic [7:0] b, input int n);
        repeat (n) text_q.push_back(b);
    endtask

    task automatic check_text(input string s);
        text_q.delete();
        add_str(s);
        send_text();
    endtask

    // name text: mostly letters, now and then any byte that is legal in a name
    task automatic add_name(input bit slashes);
        int segs;
        logic [7:0] b;
        segs = slashes ? $urandom_range(1, 3) : 1;
        for (int s = 0; s < segs; s++) begin
            if (s > 0) text_q.push_back(jdc_pkg::CH_SLASH);
            repeat ($urandom_range(1, 5)) begin
                if ($urandom_range(0, 5) == 0) begin
                    do b = 8'($urandom_range(0, 255));
                    while (b == jdc_pkg::CH_SEMI || b == jdc_pkg::CH_DOT ||
                           b == jdc_pkg::CH_LBRACK || b == jdc_pkg::CH_SLASH);
                end else begin
                    b = 8'($urandom_range(97, 122));
                end
                text_q.push_back(b);
            end
        end
    endtask

    task automatic add_field();
        int kind;
        kind = $urandom_range(0, 9);
        if (kind >= 7) add_run(jdc_pkg::CH_LBRACK, $urandom_range(1, 3));
        if (kind[0]) begin
            text_q.push_back(jdc_pkg::CH_CLASS);
            add_name(1'b1);
            text_q.push_back(jdc_pkg::CH_SEMI);
        end else begin
            text_q.push_back(BASE_SET[8 * $urandom_range(0, 7) +: 8]);
        end
    endtask

    task automatic add_method();
        text_q.push_back(jdc_pkg::CH_LPAREN);
        repeat ($urandom_range(0, 4)) add_field();
        text_q.push_back(jdc_pkg::CH_RPAREN);
        if ($urandom_range(0, 2) == 0) text_q.push_back(jdc_pkg::CH_VOID);
        else add_field();
    endtask

    // well-formed text for the mode, sometimes broken, sometimes pure noise
    task automatic build_random(input logic [1:0] m);
        int pick;
        int pos;
        text_q.delete();
        pick = $urandom_range(0, 19);
        if (pick == 0) begin
            repeat ($urandom_range(1, 6)) text_q.push_back(8'($urandom_range(0, 255)));
        end else begin
            case (m)
                jdc_pkg::MODE_METHOD: add_method();
                jdc_pkg::MODE_FIELD:  add_field();
                jdc_pkg::MODE_IDENT:  add_name(1'b0);
                default:              add_name(1'b1);
            endcase
            if (pick <= 4) begin
                pos = $urandom_range(0, text_q.size() - 1);
                case ($urandom_range(0, 3))
                    0: text_q[pos] = 8'($urandom_range(0, 255));
                    1: while (text_q.size() > pos + 1) void'(text_q.pop_back());
                    2: text_q.push_back(TRICKY_SET[8 * $urandom_range(0, 6) +: 8]);
                    default: text_q.insert(pos, TRICKY_SET[8 * $urandom_range(0, 6) +: 8]);
                endcase
            end
        end
    endtask

    initial begin
        logic [1:0] mode;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        src_idle  = 1'b1;
        sink_idle = 1'b1;

        // method descriptors
        set_mode(jdc_pkg::MODE_METHOD);
        check_text("()V");
        check_text("(BCDFIJSZ[I[[JLa;)[Ljava/lang/String;");
        check_text("(");
        check_text("()VX");
        check_text("(Q)V");
        check_text("(L;)V");
        check_text("(La//b;)V");
        check_text("(La/;)V");
        check_text("(L/a;)V");
        check_text("(La.b;)V");
        // too deep an array is only malformed here
        text_q.delete();
        add_str("(");
        add_run(jdc_pkg::CH_LBRACK, 256);
        add_str("I)V");
        send_text();

        // field descriptors
        set_mode(jdc_pkg::MODE_FIELD);
        check_text("[[J");
        check_text("Ljava/lang/Object;");
        check_text("[");
        check_text("II");
        check_text("V");
        text_q.delete();
        add_run(jdc_pkg::CH_LBRACK, 256);
        add_str("LX;");
        send_text();

        // mode switch in the middle of a string
        send_byte(jdc_pkg::CH_LBRACK, 1'b0);
        send_byte(jdc_pkg::CH_CLASS, 1'b0);
        send_byte("a", 1'b0);
        set_mode(jdc_pkg::MODE_METHOD);
        send_byte("b", 1'b0);
        send_byte(jdc_pkg::CH_SEMI, 1'b1);

        // plain identifiers and class names
        set_mode(jdc_pkg::MODE_IDENT);
        check_text("abc");
        check_text("a/b");
        check_text("a;[.");
        set_mode(jdc_pkg::MODE_CLASS);
        check_text("java/lang/Object");
        check_text("a//b");
        check_text("a/");
        check_text("/a");
        check_text("a.b");

        // random phases, quiet channels toward the end
        sent_bytes = 0;
        while (sent_bytes < RANDOM_BYTES) begin
            mode = 2'($urandom_range(0, 3));
            set_mode(mode);
            src_idle  = (sent_bytes < QUIET_TAIL) && ($urandom_range(0, 3) != 0);
            sink_idle = (sent_bytes < QUIET_TAIL) && ($urandom_range(0, 3) != 0);
            repeat ($urandom_range(6, 14)) begin
                if (sent_bytes >= QUIET_TAIL) begin
                    src_idle  = 1'b0;
                    sink_idle = 1'b0;
                end
                build_random(mode);
                send_text();
            end
        end

        // drain
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
        if (mismatches == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

endmodule
